>>> rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque bag.
// Used by bdq_cell and bounded_deque_bag; depends on nothing else.

package bdq_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Default number of cells.
  localparam int unsigned DEPTH_DEF = 16;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [OPCODE_W-1:0]      opcode_t;
  typedef logic [STATUS_W-1:0]      status_t;

  // Operation codes.
  localparam opcode_t OP_PUSH_FRONT = 3'd0;
  localparam opcode_t OP_PUSH_BACK  = 3'd1;
  localparam opcode_t OP_POP_FRONT  = 3'd2;
  localparam opcode_t OP_POP_BACK   = 3'd3;
  localparam opcode_t OP_CONTAINS   = 3'd4;
  localparam opcode_t OP_REMOVE     = 3'd5;

  // Result status codes.
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic  shift_back;   // every cell takes its front-side neighbor
    logic  shift_front;  // every cell takes its back-side neighbor
    data_t load_value;   // value for a loaded cell or for cell 0 on shift_back
  } cell_ctrl_t;

endpackage

>>> rtl/bounded_deque_bag.sv
// Top level of the bounded deque bag: controller plus a chain of bdq_cell.
// Depends on bdq_pkg and bdq_cell.

// A deque of up to DEPTH signed 32-bit values, front in cell 0, that also
// answers membership queries and removes the first match. Every transfer on
// the input gives exactly one result transfer. Push front, push back, pop
// front, pop back of a single value, any error and any lookup on an empty
// deque finish without a rotation, so such commands can follow each other
// every cycle while out_stall stays low. Contains and remove walk the whole
// contents past the single comparator at cell 0 by rotating the chain; pop
// back of more than one value rotates the remaining values to find the new
// back value. While a rotation runs, or while a result waits with out_stall
// high, in_stall is high.

module bounded_deque_bag #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Command channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  bdq_pkg::opcode_t       in_opcode,
  input  bdq_pkg::data_t         in_operand_value,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output bdq_pkg::status_t       out_status,
  output logic                   out_found,
  output bdq_pkg::data_t         out_front_value,
  output bdq_pkg::data_t         out_back_value,
  output logic [bdq_pkg::COUNT_W-1:0] out_entry_count,
  output logic                   out_is_empty
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  // Control and payload registers.
  bdq_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_left_r, scan_left_nxt;
  logic              drop_r, drop_nxt;
  logic              seek_r, seek_nxt;
  bdq_pkg::data_t    key_r, key_nxt;
  bdq_pkg::data_t    back_r, back_nxt;
  logic              out_valid_r, out_valid_nxt;
  bdq_pkg::status_t  status_r, status_nxt;
  logic              found_r, found_nxt;

  // Chain command.
  bdq_pkg::cell_ctrl_t ctrl;
  logic                load_do;
  logic [IDX_W-1:0]    load_idx;
  logic [DEPTH-1:0]    load_en;
  bdq_pkg::data_t      cell_q [DEPTH];

  logic in_xfer;
  logic is_empty;
  logic is_full;
  logic head_hit;

  assign in_stall = (state_r != bdq_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  // Only a contains or remove rotation looks for a match.
  assign head_hit = seek_r && (cell_q[0] == key_r) && !found_r;

  // Next state, chain command and result flags.
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    scan_left_nxt    = scan_left_r;
    drop_nxt         = drop_r;
    seek_nxt         = seek_r;
    key_nxt          = key_r;
    back_nxt         = back_r;
    out_valid_nxt    = out_valid_r && out_stall;
    status_nxt       = status_r;
    found_nxt        = found_r;
    ctrl.shift_back  = 1'b0;
    ctrl.shift_front = 1'b0;
    ctrl.load_value  = in_operand_value;
    load_do          = 1'b0;
    load_idx         = count_r[IDX_W-1:0];

    case (state_r)
      bdq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          out_valid_nxt = 1'b1;
          status_nxt    = bdq_pkg::STATUS_OK;
          found_nxt     = 1'b0;
          key_nxt       = in_operand_value;
          case (in_opcode)
            bdq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                status_nxt = bdq_pkg::STATUS_FULL;
              end else begin
                ctrl.shift_back = 1'b1;
                count_nxt       = count_r + CNT_W'(1);
                if (is_empty) begin
                  back_nxt = in_operand_value;
                end
              end
            end
            bdq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                status_nxt = bdq_pkg::STATUS_FULL;
              end else begin
                load_do   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                back_nxt  = in_operand_value;
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                status_nxt = bdq_pkg::STATUS_EMPTY;
              end else begin
                ctrl.shift_front = 1'b1;
                count_nxt        = count_r - CNT_W'(1);
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                status_nxt = bdq_pkg::STATUS_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                // Rotate the remaining values once to learn the new back.
                if (count_r > CNT_W'(1)) begin
                  state_nxt     = bdq_pkg::ST_SCAN;
                  scan_left_nxt = count_r - CNT_W'(1);
                  drop_nxt      = 1'b0;
                  seek_nxt      = 1'b0;
                  out_valid_nxt = 1'b0;
                end
              end
            end
            bdq_pkg::OP_CONTAINS: begin
              if (!is_empty) begin
                state_nxt     = bdq_pkg::ST_SCAN;
                scan_left_nxt = count_r;
                drop_nxt      = 1'b0;
                seek_nxt      = 1'b1;
                out_valid_nxt = 1'b0;
              end
            end
            bdq_pkg::OP_REMOVE: begin
              if (!is_empty) begin
                state_nxt     = bdq_pkg::ST_SCAN;
                scan_left_nxt = count_r;
                drop_nxt      = 1'b1;
                seek_nxt      = 1'b1;
                out_valid_nxt = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bdq_pkg::ST_SCAN: begin
        // The front value leaves cell 0 and is compared; it is either dropped
        // or put back behind the last stored value.
        ctrl.shift_front = 1'b1;
        ctrl.load_value  = cell_q[0];
        if (drop_r && head_hit) begin
          count_nxt = count_r - CNT_W'(1);
          found_nxt = 1'b1;
        end else begin
          load_do  = 1'b1;
          load_idx = IDX_W'(count_r - CNT_W'(1));
          back_nxt = cell_q[0];
          if (head_hit) begin
            found_nxt = 1'b1;
          end
        end
        scan_left_nxt = scan_left_r - CNT_W'(1);
        if (scan_left_r == CNT_W'(1)) begin
          state_nxt     = bdq_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = bdq_pkg::ST_IDLE;
      end
    endcase
  end

  // Load enable decode, one compare per cell.
  always_comb begin
    for (int i = 0; i < int'(DEPTH); i++) begin
      load_en[i] = load_do && (load_idx == IDX_W'(i));
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdq_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_left_r <= scan_left_nxt;
    drop_r      <= drop_nxt;
    seek_r      <= seek_nxt;
    key_r       <= key_nxt;
    back_r      <= back_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
  end

  // The chain of cells, cell 0 at the front.
  for (genvar g = 0; g < int'(DEPTH); g++) begin : g_cell
    bdq_pkg::data_t left_in;
    bdq_pkg::data_t right_in;

    if (g == 0) begin : g_first
      assign left_in = ctrl.load_value;
    end else begin : g_mid_left
      assign left_in = cell_q[g-1];
    end

    if (g == int'(DEPTH) - 1) begin : g_last
      assign right_in = cell_q[g];
    end else begin : g_mid_right
      assign right_in = cell_q[g+1];
    end

    bdq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .load_en  (load_en[g]),
      .left_in  (left_in),
      .right_in (right_in),
      .q        (cell_q[g])
    );
  end

  // Result ports; the contents stay put while a result waits.
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_front_value = is_empty ? '0 : cell_q[0];
  assign out_back_value  = is_empty ? '0 : back_r;
  assign out_entry_count = bdq_pkg::COUNT_W'(count_r);
  assign out_is_empty    = is_empty;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // No command is taken and no result is shown while a rotation runs.
  a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bdq_pkg::ST_SCAN) |-> (in_stall && !out_valid_r))
    else $error("activity on a channel during a rotation");

  // A full error is reported only when the deque is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == bdq_pkg::STATUS_FULL)) |-> is_full)
    else $error("full status with room left");

  // A match is only reported with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && found_r) |-> (status_r == bdq_pkg::STATUS_OK))
    else $error("match reported with an error status");

  // A rotation keeps the count or drops exactly one value.
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bdq_pkg::ST_SCAN) |=>
      (count_r == $past(count_r) || count_r == $past(count_r) - CNT_W'(1)))
    else $error("count moved by more than one during a rotation");

endmodule

>>> rtl/bdq_cell.sv
// One storage cell of the deque chain.
// Depends on bdq_pkg for the data and command types.

module bdq_cell (
  input  logic                clk,
  input  bdq_pkg::cell_ctrl_t ctrl,
  input  logic                load_en,
  input  bdq_pkg::data_t      left_in,
  input  bdq_pkg::data_t      right_in,
  output bdq_pkg::data_t      q
);

  bdq_pkg::data_t val_r;
  bdq_pkg::data_t val_nxt;

  // A shift toward the back wins, then a direct load, then a shift toward the front.
  always_comb begin
    if (ctrl.shift_back) begin
      val_nxt = left_in;
    end else if (load_en) begin
      val_nxt = ctrl.load_value;
    end else if (ctrl.shift_front) begin
      val_nxt = right_in;
    end else begin
      val_nxt = val_r;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the bounded deque bag: a directed table, then random traffic.
// Each result is checked against a behavioral predictor of the deque or, for typed table rows, against the row's want.
// Depends on bdq_pkg and the bounded_deque_bag RTL.

module testbench;
  import bdq_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_PER_PHASE = 288;
  localparam int unsigned BURST_LEN = 32;

  // Opcodes that the block leaves unused.
  localparam opcode_t OP_RSVD6 = 3'd6;
  localparam opcode_t OP_RSVD7 = 3'd7;

  localparam data_t VMAX = 32'sh7fffffff;
  localparam data_t VMIN = 32'sh80000000;

  typedef struct packed {
    status_t            status;
    logic               found;
    data_t              front;
    data_t              back;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } deque_result_t;

  // One row of the directed table; want is used only when typed is set.
  typedef struct {
    opcode_t       op;
    data_t         val;
    int            reps;
    bit            typed;
    deque_result_t want;
  } cmd_row_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  opcode_t            in_opcode = OP_PUSH_BACK;
  data_t              in_operand_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  status_t            out_status;
  logic               out_found;
  data_t              out_front_value;
  data_t              out_back_value;
  logic [COUNT_W-1:0] out_entry_count;
  logic               out_is_empty;

  // Typed expectation that travels with the command being offered.
  bit                 in_typed = 1'b0;
  deque_result_t      in_want = '0;

  // Predictor state.
  data_t              shadow_cells[DEPTH];
  int unsigned        shadow_fill = 0;

  deque_result_t      pending_results[$];
  data_t              recent_vals[8];
  cmd_row_t           directed_rows[$];
  int unsigned        recv_stall_pct = 0;
  int unsigned        n_sent = 0;
  int unsigned        n_cmds = 0;
  int unsigned        n_results = 0;
  int unsigned        n_errors = 0;
  int unsigned        n_full_err = 0;
  int unsigned        n_empty_err = 0;
  int unsigned        n_hits = 0;
  int unsigned        idle_cycles = 0;

  bounded_deque_bag #(.DEPTH(DEPTH)) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_operand_value(in_operand_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one command to the shadow deque and returns the result it must give.
  function automatic deque_result_t deque_step(opcode_t op, data_t v);
    deque_result_t r;
    int unsigned   i;
    int unsigned   pos;
    r = '0;
    r.status = STATUS_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          r.status = STATUS_FULL;
          n_full_err++;
        end else if (op == OP_PUSH_FRONT) begin
          for (i = shadow_fill; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
          shadow_cells[0] = v;
          shadow_fill++;
        end else begin
          shadow_cells[shadow_fill] = v;
          shadow_fill++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = STATUS_EMPTY;
          n_empty_err++;
        end else begin
          if (op == OP_POP_FRONT) begin
            for (i = 0; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i+1];
          end
          shadow_fill--;
        end
      end
      OP_CONTAINS, OP_REMOVE: begin
        pos = shadow_fill;
        for (i = 0; i < shadow_fill; i++) begin
          if (pos == shadow_fill && shadow_cells[i] == v) pos = i;
        end
        if (pos < shadow_fill) begin
          r.found = 1'b1;
          n_hits++;
          if (op == OP_REMOVE) begin
            for (i = pos; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i+1];
            shadow_fill--;
          end
        end
      end
      default: ;
    endcase
    if (shadow_fill > 0) begin
      r.front = shadow_cells[0];
      r.back  = shadow_cells[shadow_fill-1];
    end
    r.count = shadow_fill[COUNT_W-1:0];
    r.empty = (shadow_fill == 0);
    return r;
  endfunction

  function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Receiver: random stall at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Prediction on each command transfer, checking on each result transfer.
  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst_n && in_valid && !in_stall) begin
      want = deque_step(in_opcode, in_operand_value);
      if (in_typed) want = in_want;
      pending_results.push_back(want);
      n_cmds++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: actual %h", $time,
                 {out_status, out_found, out_front_value, out_back_value,
                  out_entry_count, out_is_empty});
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        got = '{out_status, out_found, out_front_value, out_back_value,
                out_entry_count, out_is_empty};
        n_errors += field_diff("status", want.status, got.status)
                  + field_diff("found", want.found, got.found)
                  + field_diff("front_value", want.front, got.front)
                  + field_diff("back_value", want.back, got.back)
                  + field_diff("entry_count", want.count, got.count)
                  + field_diff("is_empty", want.empty, got.empty);
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offers one command, after a random idle stretch, and waits for its transfer.
  task automatic send_cmd(opcode_t op, data_t v, bit typed, deque_result_t want,
                          int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_operand_value <= v;
    in_typed         <= typed;
    in_want          <= want;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (n_results < n_sent) @(posedge clk);
  endtask

  function automatic data_t pick_value(int unsigned recent_pct);
    if ($urandom_range(99) < recent_pct) return recent_vals[$urandom_range(7)];
    case ($urandom_range(4))
      0, 1: return data_t'($urandom);
      2:    return data_t'(int'($urandom_range(15)) - 8);
      3:    return VMAX;
      default: return VMIN;
    endcase
  endfunction

  // Random traffic in bursts that lean toward filling, emptying or neither.
  task automatic run_random(int unsigned count, int unsigned idle_pct, int unsigned stall_pct);
    int unsigned push_pct;
    int unsigned r;
    opcode_t     op;
    data_t       v;
    recv_stall_pct = stall_pct;
    push_pct = 35;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % BURST_LEN == 0) begin
        case ($urandom_range(2))
          0: push_pct = 60;
          1: push_pct = 15;
          default: push_pct = 35;
        endcase
      end
      r = $urandom_range(99);
      if (r < 3) begin
        op = $urandom_range(1) ? OP_RSVD7 : OP_RSVD6;
        v = pick_value(0);
      end else if (r < 3 + push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        v = pick_value(40);
        recent_vals[$urandom_range(7)] = v;
      end else if (r < 23 + push_pct) begin
        op = $urandom_range(1) ? OP_REMOVE : OP_CONTAINS;
        v = pick_value(60);
      end else begin
        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        v = pick_value(0);
      end
      send_cmd(op, v, 1'b0, '0, idle_pct);
    end
  endtask

  initial begin
    int unsigned idle_by_phase[4];
    int unsigned stall_by_phase[4];
    idle_by_phase  = '{0, 66, 0, 8};
    stall_by_phase = '{0, 0, 66, 8};
    foreach (recent_vals[k]) recent_vals[k] = data_t'($urandom);

    // Directed table: empty-deque errors, unused opcodes, extremes, fill to full.
    directed_rows.push_back('{OP_POP_FRONT, 32'sd0, 1, 1'b1,
                              '{STATUS_EMPTY, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{OP_POP_BACK, VMAX, 1, 1'b1,
                              '{STATUS_EMPTY, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{OP_CONTAINS, 32'sd0, 1, 1'b1,
                              '{STATUS_OK, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{OP_REMOVE, -32'sd1, 1, 1'b1,
                              '{STATUS_OK, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{OP_RSVD6, -32'sd1, 1, 1'b1,
                              '{STATUS_OK, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{OP_RSVD7, VMIN, 1, 1'b1,
                              '{STATUS_OK, 1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1}});
    directed_rows.push_back('{OP_PUSH_FRONT, VMAX, 1, 1'b1,
                              '{STATUS_OK, 1'b0, VMAX, VMAX, 5'd1, 1'b0}});
    directed_rows.push_back('{OP_PUSH_BACK, VMIN, 1, 1'b1,
                              '{STATUS_OK, 1'b0, VMAX, VMIN, 5'd2, 1'b0}});
    directed_rows.push_back('{OP_CONTAINS, VMIN, 1, 1'b1,
                              '{STATUS_OK, 1'b1, VMAX, VMIN, 5'd2, 1'b0}});
    directed_rows.push_back('{OP_REMOVE, 32'sd0, 1, 1'b1,
                              '{STATUS_OK, 1'b0, VMAX, VMIN, 5'd2, 1'b0}});
    directed_rows.push_back('{OP_PUSH_FRONT, -32'sd1, 1, 1'b0, '0});
    directed_rows.push_back('{OP_REMOVE, VMAX, 1, 1'b1,
                              '{STATUS_OK, 1'b1, -32'sd1, VMIN, 5'd2, 1'b0}});
    directed_rows.push_back('{OP_PUSH_BACK, 32'sd5, DEPTH - 2, 1'b0, '0});
    directed_rows.push_back('{OP_PUSH_FRONT, 32'sd7, 1, 1'b1,
                              '{STATUS_FULL, 1'b0, -32'sd1, 32'sd5, 5'd16, 1'b0}});
    directed_rows.push_back('{OP_PUSH_BACK, 32'sd9, 1, 1'b1,
                              '{STATUS_FULL, 1'b0, -32'sd1, 32'sd5, 5'd16, 1'b0}});
    directed_rows.push_back('{OP_CONTAINS, 32'sd5, 1, 1'b0, '0});
    directed_rows.push_back('{OP_REMOVE, 32'sd5, 1, 1'b0, '0});
    directed_rows.push_back('{OP_POP_BACK, 32'sd0, 1, 1'b0, '0});
    directed_rows.push_back('{OP_POP_FRONT, -32'sd1, 1, 1'b0, '0});
    directed_rows.push_back('{OP_RSVD6, 32'sd3, 1, 1'b0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      repeat (directed_rows[k].reps) begin
        send_cmd(directed_rows[k].op, directed_rows[k].val, directed_rows[k].typed,
                 directed_rows[k].want, 0);
      end
    end
    drain_results();

    // Random phases, each drained before the next stall pattern starts.
    for (int p = 0; p < 4; p++) begin
      run_random(RANDOM_PER_PHASE, idle_by_phase[p], stall_by_phase[p]);
      drain_results();
    end
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      n_errors++;
    end
    $display("Covered %0d commands and %0d results over four handshake idle patterns.",
             n_cmds, n_results);
    $display("Seen: %0d full errors, %0d empty errors, %0d search matches, %0d mismatches.",
             n_full_err, n_empty_err, n_hits, n_errors);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
